/* rtl/core/ikf_pkg.sv */
// shared types and constants of the angle kalman filter
`timescale 1ns / 1ps
`default_nettype none

package ikf_pkg;

   // fraction bits of the covariance, gain and time formats
   localparam int FRAC_BITS = 30;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_NOISE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_NOISE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE = 2'd3;

   localparam logic [CSR_DATA_W-1:0] SAMPLE_PERIOD_RST = 31'd5368709;
   localparam logic [CSR_DATA_W-1:0] ANGLE_NOISE_RST   = 31'd1073742;
   localparam logic [CSR_DATA_W-1:0] BIAS_NOISE_RST    = 31'd5368709;
   localparam logic [CSR_DATA_W-1:0] MEASURE_NOISE_RST = 31'd536870912;

   // stream field widths
   localparam int ACCEL_W    = 25;
   localparam int GYRO_W     = 28;
   localparam int REQ_DATA_W = 56;
   localparam int OUT_W      = 32;
   localparam int RSP_DATA_W = 64;

   // command from the sequencer to the shared arithmetic unit
   typedef struct packed {
      logic start;
      logic op_div;
   } ikf_cmd_type;

endpackage

`default_nettype wire

/* rtl/core/ikf_arith_unit.sv */
// shared bit-serial multiply and divide unit with q2.30 scaling and clamping
`timescale 1ns / 1ps
`default_nettype none

module ikf_arith_unit import ikf_pkg::*; #(
   parameter int WORD_WIDTH = 32,
   localparam int MW = (WORD_WIDTH > 31) ? WORD_WIDTH : 31,
   localparam int AW = MW + 1,
   localparam int RW = WORD_WIDTH + 2
) (
   input  wire                    clock,
   input  wire                    reset,
   input  ikf_cmd_type            cmd,
   input  wire logic signed [AW-1:0] opnd_a,
   input  wire logic signed [AW-1:0] opnd_b,
   output logic                   done,
   output logic signed [RW-1:0]   result
);

   localparam int DW = MW + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);
   localparam logic [CW-1:0] MUL_LAST = CW'(MW - 1);
   localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);
   localparam logic [2*MW-1:0] LIM_P = (2*MW)'(1) << WORD_WIDTH;
   localparam logic [WORD_WIDTH:0] LIM_Q = (WORD_WIDTH+1)'(1) << WORD_WIDTH;

   typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} ustate_type;

   ustate_type                 state_ff;
   logic [CW-1:0]              cnt_ff;
   logic                       is_div_ff;
   logic                       neg_ff;
   logic [MW-1:0]              mcand_ff;
   logic [MW:0]                hi_ff;
   logic [MW-1:0]              lo_ff;
   logic [DW-1:0]              dvd_ff;
   logic [MW-1:0]              dsr_ff;
   logic [MW-1:0]              rem_ff;
   logic [WORD_WIDTH:0]        quo_ff;
   logic                       sticky_ff;
   logic                       done_ff;
   logic signed [RW-1:0]       result_ff;

   logic [MW-1:0]              mag_a;
   logic [MW-1:0]              mag_b;
   logic [MW:0]                sum_in;
   logic [MW:0]                rem_sh;
   logic                       ge;
   logic [MW-1:0]              rem_in;
   logic [2*MW-1:0]            prod;
   logic [2*MW-1:0]            shr;
   logic [WORD_WIDTH:0]        mag_out;
   logic signed [RW-1:0]       result_in;

   // operand magnitudes
   always_comb begin
      mag_a = (opnd_a < 0) ? MW'(-opnd_a) : MW'(opnd_a);
      mag_b = (opnd_b < 0) ? MW'(-opnd_b) : MW'(opnd_b);
   end

   // one shift-add step and one restoring divide step
   always_comb begin
      sum_in = hi_ff + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      rem_sh = {rem_ff, dvd_ff[DW-1]};
      ge     = rem_sh >= {1'b0, dsr_ff};
      rem_in = ge ? MW'(rem_sh - {1'b0, dsr_ff}) : rem_sh[MW-1:0];
   end

   // scale, clamp and sign the finished value
   always_comb begin
      prod = {hi_ff[MW-1:0], lo_ff};
      shr  = prod >> FRAC_BITS;
      if (is_div_ff) begin
         mag_out = (sticky_ff || quo_ff > LIM_Q) ? LIM_Q : quo_ff;
      end else begin
         mag_out = (shr > LIM_P) ? LIM_Q : shr[WORD_WIDTH:0];
      end
      result_in = neg_ff ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
   end

   // sequencing of the unit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            U_IDLE: begin
               if (cmd.start) begin
                  cnt_ff    <= '0;
                  is_div_ff <= cmd.op_div;
                  mcand_ff  <= mag_a;
                  hi_ff     <= '0;
                  lo_ff     <= mag_b;
                  dvd_ff    <= {mag_a, {FRAC_BITS{1'b0}}};
                  dsr_ff    <= opnd_b[MW-1:0];
                  rem_ff    <= '0;
                  quo_ff    <= '0;
                  sticky_ff <= 1'b0;
                  if (cmd.op_div) begin
                     neg_ff   <= opnd_a < 0;
                     state_ff <= U_DIV;
                  end else begin
                     neg_ff   <= (opnd_a < 0) != (opnd_b < 0);
                     state_ff <= U_MUL;
                  end
               end
            end
            U_MUL: begin
               hi_ff  <= sum_in >> 1;
               lo_ff  <= {sum_in[0], lo_ff[MW-1:1]};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == MUL_LAST) begin
                  state_ff <= U_FIN;
               end
            end
            U_DIV: begin
               rem_ff    <= rem_in;
               dvd_ff    <= dvd_ff << 1;
               quo_ff    <= {quo_ff[WORD_WIDTH-1:0], ge};
               sticky_ff <= sticky_ff | quo_ff[WORD_WIDTH];
               cnt_ff    <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_LAST) begin
                  state_ff <= U_FIN;
               end
            end
            U_FIN: begin
               result_ff <= result_in;
               done_ff   <= 1'b1;
               state_ff  <= U_IDLE;
            end
            default: state_ff <= U_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

/* rtl/core/imu_angle_kalman_filter.sv */
// top level: two-state kalman filter for angle and gyro bias, with sequencer
`timescale 1ns / 1ps
`default_nettype none

// Each transaction on req carries an accelerometer angle and a gyro rate (Q16.16);
// one transaction on rsp returns the fused angle and the bias-corrected rate.
// All arithmetic runs through one bit-serial multiply/divide unit under a small
// sequencer: eleven multiplies and two divides on operands of MW bits magnitude,
// where MW is the larger of WORD_WIDTH and 31, plus the idle state that accepts
// an item and the output state. When the innovation variance is not positive both
// divides are skipped. req_tready is high only while the sequencer is idle; a
// finished result waits in the output register so the next transaction can be
// taken meanwhile. The csr registers should only be written while no transaction
// is in flight.
module imu_angle_kalman_filter import ikf_pkg::*; #(
   parameter int WORD_WIDTH = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [REQ_DATA_W-1:0]   req_tdata,   // accel_angle[24:0], gyro_rate[52:25], zero pad
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // angle_estimate[31:0], rate_estimate[63:32]
   input  wire                    csr_we,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int W  = WORD_WIDTH;
   localparam int MW = (W > 31) ? W : 31;
   localparam int AW = MW + 1;
   localparam int XW = MW + 3;
   localparam int RW = W + 2;
   localparam logic signed [XW-1:0] WMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] WMIN = ~WMAX;
   localparam logic signed [XW-1:0] OMAX = {{(XW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic signed [XW-1:0] OMIN = ~OMAX;
   localparam logic signed [XW-1:0] COV_ONE = XW'(64'sd1073741824);

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_type;
   typedef enum logic [3:0] {
      OP_ANGLE_PRED, OP_AA_PRED, OP_AB_PRED, OP_BA_PRED, OP_BB_PRED,
      OP_K0, OP_K1,
      OP_ANGLE_CORR, OP_BIAS_CORR,
      OP_AA_CORR, OP_AB_CORR, OP_BA_CORR, OP_BB_CORR
   } op_type;

   function automatic logic signed [W-1:0] sat_word(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] c;
      c = (v > WMAX) ? WMAX : ((v < WMIN) ? WMIN : v);
      return c[W-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] c;
      c = (v > OMAX) ? OMAX : ((v < OMIN) ? OMIN : v);
      return c[OUT_W-1:0];
   endfunction

   // configuration registers
   logic [CSR_DATA_W-1:0]      dt_ff;
   logic [CSR_DATA_W-1:0]      an_ff;
   logic [CSR_DATA_W-1:0]      bn_ff;
   logic [CSR_DATA_W-1:0]      mn_ff;

   // filter state and per-item scratch
   state_type                  state_ff;
   op_type                     op_ff;
   logic signed [ACCEL_W-1:0]  accel_ff;
   logic signed [GYRO_W-1:0]   gyro_ff;
   logic signed [W-1:0]        angle_ff;
   logic signed [W-1:0]        bias_ff;
   logic signed [W-1:0]        aa_ff;
   logic signed [W-1:0]        ab_ff;
   logic signed [W-1:0]        ba_ff;
   logic signed [W-1:0]        bb_ff;
   logic signed [W-1:0]        k0_ff;
   logic signed [W-1:0]        k1_ff;
   logic signed [W-1:0]        err_ff;
   logic signed [W-1:0]        t0_ff;
   logic signed [W-1:0]        t1_ff;
   logic                       rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]      rsp_tdata_ff;

   logic signed [XW-1:0]       gyro_x;
   logic signed [XW-1:0]       bias_x;
   logic signed [W-1:0]        rate_pred;
   logic signed [W-1:0]        noise_sum;
   logic signed [W-1:0]        e_c;
   logic signed [W-1:0]        err_c;
   logic                       skip_div;
   logic signed [AW-1:0]       opnd_a;
   logic signed [AW-1:0]       opnd_b;
   logic signed [W-1:0]        wb_base;
   logic                       wb_sub;
   logic signed [XW-1:0]       r_x;
   logic signed [W-1:0]        wb_val;
   ikf_cmd_type                unit_cmd;
   logic                       unit_done;
   logic signed [RW-1:0]       unit_result;

   // shared multiply and divide unit
   ikf_arith_unit #(.WORD_WIDTH(WORD_WIDTH)) u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .done   (unit_done),
      .result (unit_result)
   );

   // intermediate sums for prediction, gain and innovation
   always_comb begin
      gyro_x    = XW'(gyro_ff);
      bias_x    = XW'(bias_ff);
      rate_pred = sat_word(gyro_x - bias_x);
      noise_sum = sat_word(XW'($signed({1'b0, an_ff})) - XW'(ab_ff) - XW'(ba_ff));
      e_c       = sat_word(XW'($signed({1'b0, mn_ff})) + XW'(aa_ff));
      err_c     = sat_word(XW'(accel_ff) - XW'(angle_ff));
      skip_div  = (op_ff == OP_K0) && (e_c <= 0);
   end

   // operand selection and write-back target per step
   always_comb begin
      opnd_a  = '0;
      opnd_b  = AW'($signed({1'b0, dt_ff}));
      wb_base = '0;
      wb_sub  = 1'b0;
      unique case (op_ff)
         OP_ANGLE_PRED: begin
            opnd_a  = AW'(rate_pred);
            wb_base = angle_ff;
         end
         OP_AA_PRED: begin
            opnd_a  = AW'(noise_sum);
            wb_base = aa_ff;
         end
         OP_AB_PRED: begin
            opnd_a  = AW'(bb_ff);
            wb_base = ab_ff;
            wb_sub  = 1'b1;
         end
         OP_BA_PRED: begin
            opnd_a  = AW'(bb_ff);
            wb_base = ba_ff;
            wb_sub  = 1'b1;
         end
         OP_BB_PRED: begin
            opnd_a  = AW'($signed({1'b0, bn_ff}));
            wb_base = bb_ff;
         end
         OP_K0: begin
            opnd_a = AW'(aa_ff);
            opnd_b = AW'(e_c);
         end
         OP_K1: begin
            opnd_a = AW'(ba_ff);
            opnd_b = AW'(e_c);
         end
         OP_ANGLE_CORR: begin
            opnd_a  = AW'(k0_ff);
            opnd_b  = AW'(err_c);
            wb_base = angle_ff;
         end
         OP_BIAS_CORR: begin
            opnd_a  = AW'(k1_ff);
            opnd_b  = AW'(err_ff);
            wb_base = bias_ff;
         end
         OP_AA_CORR: begin
            opnd_a  = AW'(k0_ff);
            opnd_b  = AW'(aa_ff);
            wb_base = aa_ff;
            wb_sub  = 1'b1;
         end
         OP_AB_CORR: begin
            opnd_a  = AW'(k0_ff);
            opnd_b  = AW'(ab_ff);
            wb_base = ab_ff;
            wb_sub  = 1'b1;
         end
         OP_BA_CORR: begin
            opnd_a  = AW'(k1_ff);
            opnd_b  = AW'(t0_ff);
            wb_base = ba_ff;
            wb_sub  = 1'b1;
         end
         OP_BB_CORR: begin
            opnd_a  = AW'(k1_ff);
            opnd_b  = AW'(t1_ff);
            wb_base = bb_ff;
            wb_sub  = 1'b1;
         end
         default: begin
            opnd_a = '0;
         end
      endcase
      r_x    = XW'(unit_result);
      wb_val = sat_word(wb_sub ? (XW'(wb_base) - r_x) : (XW'(wb_base) + r_x));
   end

   // unit command
   always_comb begin
      unit_cmd.start  = (state_ff == ST_ISSUE) && !skip_div;
      unit_cmd.op_div = (op_ff == OP_K0) || (op_ff == OP_K1);
   end

   // sequencer, filter state, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_ANGLE_PRED;
         rsp_tvalid_ff <= 1'b0;
         dt_ff         <= SAMPLE_PERIOD_RST;
         an_ff         <= ANGLE_NOISE_RST;
         bn_ff         <= BIAS_NOISE_RST;
         mn_ff         <= MEASURE_NOISE_RST;
         angle_ff      <= '0;
         bias_ff       <= '0;
         aa_ff         <= sat_word(COV_ONE);
         ab_ff         <= '0;
         ba_ff         <= '0;
         bb_ff         <= sat_word(COV_ONE);
         k0_ff         <= '0;
         k1_ff         <= '0;
      end else begin
         // register writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAMPLE_PERIOD: dt_ff <= csr_wdata;
               CSR_ANGLE_NOISE:   an_ff <= csr_wdata;
               CSR_BIAS_NOISE:    bn_ff <= csr_wdata;
               CSR_MEASURE_NOISE: mn_ff <= csr_wdata;
               default:           dt_ff <= dt_ff;
            endcase
         end

         // the output state reloads or holds the output register itself
         if (rsp_tready && (state_ff != ST_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  accel_ff <= req_tdata[ACCEL_W-1:0];
                  gyro_ff  <= req_tdata[ACCEL_W+GYRO_W-1:ACCEL_W];
                  op_ff    <= OP_ANGLE_PRED;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               if (skip_div) begin
                  // no positive innovation variance: no correction
                  k0_ff <= '0;
                  k1_ff <= '0;
                  op_ff <= OP_ANGLE_CORR;
               end else begin
                  state_ff <= ST_WAIT;
               end
               if (op_ff == OP_ANGLE_CORR) begin
                  err_ff <= err_c;
               end
               if (op_ff == OP_AA_CORR) begin
                  t0_ff <= aa_ff;
               end
               if (op_ff == OP_AB_CORR) begin
                  t1_ff <= ab_ff;
               end
            end
            ST_WAIT: begin
               if (unit_done) begin
                  unique case (op_ff)
                     OP_ANGLE_PRED, OP_ANGLE_CORR: angle_ff <= wb_val;
                     OP_AA_PRED, OP_AA_CORR:       aa_ff    <= wb_val;
                     OP_AB_PRED, OP_AB_CORR:       ab_ff    <= wb_val;
                     OP_BA_PRED, OP_BA_CORR:       ba_ff    <= wb_val;
                     OP_BB_PRED, OP_BB_CORR:       bb_ff    <= wb_val;
                     OP_K0:                        k0_ff    <= sat_word(r_x);
                     OP_K1:                        k1_ff    <= sat_word(r_x);
                     OP_BIAS_CORR:                 bias_ff  <= wb_val;
                     default:                      k0_ff    <= k0_ff;
                  endcase
                  if (op_ff == OP_BB_CORR) begin
                     state_ff <= ST_OUT;
                  end else begin
                     op_ff    <= op_type'(op_ff + 4'd1);
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= {sat_out(gyro_x - bias_x), sat_out(XW'(angle_ff))};
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // an accepted transaction starts the first prediction step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_ISSUE && op_ff == OP_ANGLE_PRED))
      else $error("accepted transaction did not start the sequence");

   // the unit only finishes while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> (state_ff == ST_WAIT))
      else $error("arith unit finished outside of wait state");

   // a divide is only issued with a positive denominator
   a_div_positive: assert property (@(posedge clock) disable iff (reset)
      (unit_cmd.start && unit_cmd.op_div) |-> (e_c > 0))
      else $error("divide issued with nonpositive denominator");

   // a new result only comes out of the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result presented outside of output state");

endmodule

`default_nettype wire

/* tb/tb_imu_angle_kalman_filter.sv */
// self-checking testbench of the angle and gyro bias kalman filter
`timescale 1ns / 1ps

module tb_imu_angle_kalman_filter;
   import ikf_pkg::*;

   localparam longint BIG_MAG    = 64'sh4000_0000_0000_0000;
   localparam longint ACCEL_MAX  = 11796480;
   localparam longint GYRO_MAX   = 131072000;
   localparam longint GYRO_OFS   = 655360;
   localparam longint ONE_Q30    = 1073741824;
   localparam logic [CSR_DATA_W-1:0] REG_MAX = 31'h7FFF_FFFF;
   localparam int     STALL_LIMIT = 40000;
   localparam int     LONG_HOLD   = 3000;
   localparam int     DRAIN_WAIT  = 700;

   // rate in the upper half, angle in the lower half of the result word
   typedef struct packed {
      logic [31:0] rate;
      logic [31:0] angle;
   } fused_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   imu_angle_kalman_filter DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // filter copy: configuration and state
   longint dt_q, angle_q, bias_q, meas_q;
   longint ang_st, bias_st, p_aa, p_ab, p_ba, p_bb;

   logic [REQ_DATA_W-1:0] sample_queue[$];
   fused_type             fused_queue[$];
   int mismatches = 0;
   int sender_mode = 0;
   int receiver_mode = 0;
   bit hold_req = 1'b0;
   bit hold_taken = 1'b0;
   int hold_cnt = 0;
   int burst_left = 0;
   int gap_left = 0;
   int idle_cycles = 0;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint capped(logic [127:0] m, bit neg);
      longint s;
      if (m > 128'(BIG_MAG)) s = BIG_MAG;
      else s = longint'(m[63:0]);
      return neg ? -s : s;
   endfunction

   // (a * b) >> 30 truncated toward zero
   function automatic longint mul_frac(longint a, longint b);
      logic [127:0] ua, ub, p;
      ua = (a < 0) ? 128'(-a) : 128'(a);
      ub = (b < 0) ? 128'(-b) : 128'(b);
      p = (ua * ub) >> FRAC_BITS;
      return capped(p, (a < 0) != (b < 0));
   endfunction

   // (n << 30) / d truncated toward zero, d positive
   function automatic longint div_frac(longint n, longint d);
      logic [127:0] un, ud;
      un = (n < 0) ? 128'(-n) : 128'(n);
      ud = 128'(d);
      if ((un / ud) >= 128'h1_0000_0000) return capped(128'(BIG_MAG), n < 0);
      return capped((un << FRAC_BITS) / ud, n < 0);
   endfunction

   function automatic fused_type kalman_update(logic [REQ_DATA_W-1:0] d);
      longint accel, gyro, e, k0, k1, err, t0, t1, rate;
      fused_type r;
      accel = longint'(signed'(d[ACCEL_W-1:0]));
      gyro  = longint'(signed'(d[ACCEL_W+GYRO_W-1:ACCEL_W]));
      k0 = 0;
      k1 = 0;
      // predict
      ang_st = sat32(ang_st + mul_frac(sat32(gyro - bias_st), dt_q));
      p_aa = sat32(p_aa + mul_frac(sat32(angle_q - p_ab - p_ba), dt_q));
      p_ab = sat32(p_ab + mul_frac(-p_bb, dt_q));
      p_ba = sat32(p_ba + mul_frac(-p_bb, dt_q));
      p_bb = sat32(p_bb + mul_frac(bias_q, dt_q));
      // gains, skipped on a nonpositive innovation variance
      e = sat32(meas_q + p_aa);
      if (e > 0) begin
         k0 = sat32(div_frac(p_aa, e));
         k1 = sat32(div_frac(p_ba, e));
      end
      // correct
      err = sat32(accel - ang_st);
      ang_st = sat32(ang_st + mul_frac(k0, err));
      bias_st = sat32(bias_st + mul_frac(k1, err));
      t0 = p_aa;
      t1 = p_ab;
      p_aa = sat32(p_aa - mul_frac(k0, t0));
      p_ab = sat32(p_ab - mul_frac(k0, t1));
      p_ba = sat32(p_ba - mul_frac(k1, t0));
      p_bb = sat32(p_bb - mul_frac(k1, t1));
      rate = sat32(gyro - bias_st);
      r.angle = ang_st[31:0];
      r.rate  = rate[31:0];
      return r;
   endfunction

   // sender: bursts and gaps, holds an offered transaction until taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            fused_queue.push_back(kalman_update(req_tdata));
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= sample_queue.pop_front();
            if (sender_mode != 0) begin
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 6);
                  gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 700)
                                                          : $urandom_range(0, 40);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cnt <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (receiver_mode == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      fused_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (fused_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result angle=%h rate=%h", got.angle, got.rate);
         end else begin
            want = fused_queue.pop_front();
            if (want.angle !== got.angle || want.rate !== got.rate) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch angle exp=%h got=%h rate exp=%h got=%h",
                           want.angle, got.angle, want.rate, got.rate);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SAMPLE_PERIOD: dt_q = longint'(val);
         CSR_ANGLE_NOISE:   angle_q = longint'(val);
         CSR_BIAS_NOISE:    bias_q = longint'(val);
         default:           meas_q = longint'(val);
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_filter(logic [CSR_DATA_W-1:0] dt, logic [CSR_DATA_W-1:0] qa,
                             logic [CSR_DATA_W-1:0] qb, logic [CSR_DATA_W-1:0] rm);
      write_reg(CSR_SAMPLE_PERIOD, dt);
      write_reg(CSR_ANGLE_NOISE, qa);
      write_reg(CSR_BIAS_NOISE, qb);
      write_reg(CSR_MEASURE_NOISE, rm);
   endtask

   task automatic drain();
      while (sample_queue.size() > 0 || req_tvalid || fused_queue.size() > 0)
         @(posedge clock);
   endtask

   task automatic push_sample(longint accel, longint gyro);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[ACCEL_W-1:0] = accel[ACCEL_W-1:0];
      d[ACCEL_W+GYRO_W-1:ACCEL_W] = gyro[GYRO_W-1:0];
      sample_queue.push_back(d);
   endtask

   function automatic longint rand_span(longint lim);
      return longint'($urandom_range(0, 32'(2 * lim))) - lim;
   endfunction

   // mostly a smooth motion track with sensor noise, some uniform noise items
   task automatic push_random(int n);
      longint ang, rate;
      ang = rand_span(ACCEL_MAX);
      rate = rand_span(GYRO_MAX / 8);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            push_sample(rand_span(ACCEL_MAX), rand_span(GYRO_MAX));
         end else begin
            rate = rate + rand_span(GYRO_MAX / 64);
            if (rate > GYRO_MAX - GYRO_OFS) rate = GYRO_MAX - GYRO_OFS;
            if (rate < -GYRO_MAX) rate = -GYRO_MAX;
            ang = ang + rate / 200 + rand_span(65536);
            if (ang > ACCEL_MAX) ang = ACCEL_MAX;
            if (ang < -ACCEL_MAX) ang = -ACCEL_MAX;
            push_sample(ang, rate + GYRO_OFS);
         end
      end
   endtask

   function automatic logic [CSR_DATA_W-1:0] rand_reg(bit nonzero);
      case ($urandom_range(0, 3))
         0: return nonzero ? 31'd1 : 31'd0;
         1: return REG_MAX;
         2: return 31'($urandom_range(1, 31'd53687091));
         default: return 31'($urandom() & REG_MAX);
      endcase
   endfunction

   // stimulus sequence and end of run
   initial begin
      dt_q = longint'(SAMPLE_PERIOD_RST);
      angle_q = longint'(ANGLE_NOISE_RST);
      bias_q = longint'(BIAS_NOISE_RST);
      meas_q = longint'(MEASURE_NOISE_RST);
      ang_st = 0;
      bias_st = 0;
      p_aa = ONE_Q30;
      p_ab = 0;
      p_ba = 0;
      p_bb = ONE_Q30;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes at the reset settings
      push_sample(ACCEL_MAX, GYRO_MAX);
      push_sample(-ACCEL_MAX, -GYRO_MAX);
      push_sample(0, 0);
      push_sample(ACCEL_MAX, -GYRO_MAX);
      push_sample(-ACCEL_MAX, GYRO_MAX);
      push_sample(-1, -1);
      push_sample(1, 1);
      drain();

      // zero sample period: prediction changes nothing
      set_filter(31'd0, ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST);
      push_sample(ACCEL_MAX, GYRO_MAX);
      push_sample(-ACCEL_MAX, -GYRO_MAX);
      drain();

      // largest settings drive products and quotients into saturation
      set_filter(REG_MAX, REG_MAX, REG_MAX, REG_MAX);
      push_sample(ACCEL_MAX, GYRO_MAX);
      push_sample(-ACCEL_MAX, -GYRO_MAX);
      push_sample(ACCEL_MAX, -GYRO_MAX);
      push_sample(0, GYRO_MAX);
      drain();

      // smallest settings, tiny measurement noise, nonpositive innovation likely
      set_filter(31'd1, 31'd0, 31'd0, 31'd1);
      push_sample(-ACCEL_MAX, GYRO_MAX);
      push_sample(ACCEL_MAX, 0);
      drain();
      set_filter(REG_MAX, 31'd0, REG_MAX, 31'd1);
      push_sample(ACCEL_MAX, GYRO_MAX);
      push_sample(-ACCEL_MAX, -GYRO_MAX);
      push_sample(ACCEL_MAX, -GYRO_MAX);
      drain();

      // back to nominal, long receiver hold-off while the sender keeps offering
      set_filter(SAMPLE_PERIOD_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST);
      hold_req = 1'b1;
      push_random(40);
      drain();

      // random phases with random settings and idling
      for (int ph = 0; ph < 14; ph++) begin
         sender_mode = ph % 3;
         receiver_mode = (ph % 4 != 0);
         if (ph % 2 == 0)
            set_filter(31'(SAMPLE_PERIOD_RST + $urandom_range(0, 31'd50000000)),
                       31'($urandom_range(0, 31'd20000000)),
                       31'($urandom_range(0, 31'd20000000)),
                       31'($urandom_range(1, 31'd1073741824)));
         else
            set_filter(rand_reg(1'b0), rand_reg(1'b0), rand_reg(1'b0), rand_reg(1'b1));
         push_random(80);
      drain();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && fused_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
